@@ design/b2a_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2a_pkg: shared types and constants of the binary to ASCII decimal converter
// Holds field widths, the queue entry type, the back-end state type and the
// power-of-ten table used by the digit extraction unit.
// ----------------------------------------------------------------------------
package b2a_pkg;

  // Field widths.
  localparam int unsigned NumW       = 32;
  localparam int unsigned CntW       = 4;
  localparam int unsigned DigitW     = 6;
  localparam int unsigned InTdataW   = 40;
  localparam int unsigned OutTdataW  = 8;

  // Default digit limit and the widest count that the power table covers.
  localparam int unsigned MaxDigitsDef = 10;

  // Width of the power-of-ten multiples; 9 * 10^9 needs 34 bits.
  localparam int unsigned PowW = 34;

  // Queue depth between the front and the back end.
  localparam int unsigned QueueDepth = 2;

  // Highest decimal position of a 32-bit number.
  localparam logic [CntW-1:0] TopExp = 4'd9;

  // ASCII code of the digit zero and the decimal radix.
  localparam logic [DigitW-1:0] AsciiZero = 6'd48;
  localparam int unsigned       Radix     = 10;

  // One queued number with its saturated, nonzero digit count.
  typedef struct packed {
    logic [NumW-1:0] number;
    logic [CntW-1:0] count;
  } b2a_item_t;

  // Back-end sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } b2a_state_e;

  // 10 raised to a decimal position, 0 to 9.
  function automatic logic [PowW-1:0] pow_ten(input logic [CntW-1:0] exp);
    logic [PowW-1:0] p;
    case (exp)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

@@ design/binary_to_ascii_decimal.sv @@
`timescale 1ns / 1ps
// Each number is written as digit_count ASCII decimal digits, most significant
// first, with tlast on the final digit; leading zeros are kept, digits above
// the count are dropped, counts above MAX_DIGITS act as MAX_DIGITS and a count
// of zero emits nothing. The back end loads each number from the two-entry
// input queue, then walks the positions from 10^9 down to the units, one per
// cycle unless the output is full, using the single digit unit that compares
// the value against the nine multiples of the current power of ten. A number
// with a zero count is taken at the input and never reaches the back end.
// ----------------------------------------------------------------------------
// binary_to_ascii_decimal: 32-bit binary to fixed-width ASCII decimal
// Top level tying the input stage, the number queue and the digit back end
// to the input and output stream ports.
// ----------------------------------------------------------------------------
module binary_to_ascii_decimal
  import b2a_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [31:0] number, [35:32] digit_count, [39:36] unused
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [5:0] ascii_digit, [7:6] zero
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  output logic                 m_axis_tlast_o
);

  logic              push;
  b2a_item_t         push_item;
  logic              pop;
  b2a_item_t         pop_item;
  logic              queue_full;
  logic              queue_empty;
  logic [DigitW-1:0] ascii_digit;

  b2a_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_o   (s_axis_tready_o),
    .number_i     (s_axis_tdata_i[NumW-1:0]),
    .digit_count_i(s_axis_tdata_i[NumW+CntW-1:NumW]),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  b2a_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .pop_item_o (pop_item),
    .full_o     (queue_full),
    .empty_o    (queue_empty)
  );

  b2a_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_item_i   (pop_item),
    .empty_i      (queue_empty),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .ascii_digit_o(ascii_digit),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {(OutTdataW - DigitW)'(0), ascii_digit};

endmodule

@@ design/b2a_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2a_front: input stage of the converter
// Accepts number transactions, limits the digit count to the configured
// maximum and drops numbers that ask for no digits before they reach the queue.
// ----------------------------------------------------------------------------
module b2a_front
  import b2a_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [NumW-1:0]     number_i,
  input  logic [CntW-1:0]     digit_count_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output b2a_item_t           push_item_o
);

  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_DIGITS);

  logic [CntW-1:0] count_sat;

  // Take a transaction whenever the queue has room.
  assign s_tready_o = !queue_full_i;

  // Saturate the count at the configured maximum digit count.
  assign count_sat = (digit_count_i > MaxCount) ? MaxCount : digit_count_i;

  // A zero count produces no output, so it never enters the queue.
  assign push_o             = s_tvalid_i && !queue_full_i && (count_sat != '0);
  assign push_item_o.number = number_i;
  assign push_item_o.count  = count_sat;

endmodule

@@ design/b2a_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2a_queue: short queue between the front and the back end
// A small register FIFO that lets the input side accept the next number
// while the back end is still emitting digits of an earlier one.
// ----------------------------------------------------------------------------
module b2a_queue
  import b2a_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  b2a_item_t push_item_i,
  input  logic      pop_i,
  output b2a_item_t pop_item_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FillW = $clog2(DEPTH + 1);

  b2a_item_t             entry_q [DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]      fill_q, fill_d;
  logic                  do_push, do_pop;

  assign full_o  = (fill_q == FillW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign pop_item_o = entry_q[rd_ptr_q];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ design/b2a_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2a_back: digit extraction and output stage
// Walks a queued number from the 10^9 position down to the units, finding one
// decimal digit per cycle while the output is free, and sends the digits below
// the requested count to a registered output, MSB first, with tlast on units.
// ----------------------------------------------------------------------------
module b2a_back
  import b2a_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b2a_item_t         pop_item_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DigitW-1:0] ascii_digit_o,
  output logic              last_o
);

  b2a_state_e        state_q, state_d;
  logic [NumW-1:0]   value_q, value_d;
  logic [CntW-1:0]   exp_q, exp_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [DigitW-1:0] out_digit_q, out_digit_d;
  logic              out_last_q, out_last_d;

  logic [CntW-1:0]   digit_k;
  logic [PowW-1:0]   sub_val;
  logic [NumW-1:0]   rem_val;
  logic              emit;
  logic              out_free;
  logic              advance;
  logic              out_load;

  // Digit unit: compare the value against the nine multiples of 10^exp.
  always_comb begin
    logic [PowW-1:0] mult;
    digit_k = '0;
    sub_val = '0;
    for (int k = 1; k < Radix; k++) begin
      mult = pow_ten(exp_q) * PowW'(k);
      if ({2'b00, value_q} >= mult) begin
        digit_k = CntW'(k);
        sub_val = mult;
      end
    end
  end

  assign rem_val = NumW'({2'b00, value_q} - sub_val);

  // A position at or above the count is dropped and costs no output slot.
  assign emit     = (exp_q < count_q);
  assign out_free = !out_valid_q || m_tready_i;
  assign advance  = (state_q == ST_CONV) && (!emit || out_free);
  assign out_load = advance && emit;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    exp_q       <= exp_d;
    count_q     <= count_d;
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
  end

  // Sequencer and output register control.
  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    exp_d       = exp_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;

    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          value_d = pop_item_i.number;
          count_d = pop_item_i.count;
          exp_d   = TopExp;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (advance) begin
          value_d = rem_val;
          exp_d   = exp_q - 1'b1;
          if (exp_q == '0) begin
            state_d = ST_IDLE;
          end
        end
        if (out_load) begin
          out_valid_d = 1'b1;
          out_digit_d = AsciiZero + DigitW'(digit_k);
          out_last_d  = (exp_q == '0);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid_o    = out_valid_q;
  assign ascii_digit_o = out_digit_q;
  assign last_o        = out_last_q;

  // The digit code shown on the output is always a decimal digit.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_digit_q >= AsciiZero) && (out_digit_q <= AsciiZero + 6'd9))
    else $error("output digit code out of range");

  // The remaining value always fits below the next higher power of ten.
  a_value_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> ({2'b00, value_q} < pow_ten(exp_q) * PowW'(Radix)))
    else $error("remaining value too large for digit position");

  // Only nonzero counts within the limit ever reach the back end.
  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> (count_q != '0) && (count_q <= CntW'(MAX_DIGITS)))
    else $error("queued digit count out of range");

  // Loading the units digit ends the conversion.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (exp_q == '0)) |=> (state_q == ST_IDLE) && out_valid_q && out_last_q)
    else $error("conversion did not end on the final digit");

endmodule
